// ===== src/stbe_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stbe_pkg
// Shared types and codes for the sorted triple bitmap encoder.
// ----------------------------------------------------------------------------
package stbe_pkg;

    localparam int FIELD_BITS = 32;

    localparam logic [2:0] ST_OK          = 3'd0;
    localparam logic [2:0] ST_ZERO_SKIP   = 3'd1;
    localparam logic [2:0] ST_SUBJECT_GAP = 3'd2;
    localparam logic [2:0] ST_PRED_DEC    = 3'd3;
    localparam logic [2:0] ST_OBJ_ORDER   = 3'd4;
    localparam logic [2:0] ST_HALTED      = 3'd5;

    typedef enum logic [3:0] {
        K_FIRST,
        K_NEW_SUBJ,
        K_NEW_PRED,
        K_SAME_PRED,
        K_EOS,
        K_ZERO,
        K_GAP,
        K_PRED_DEC,
        K_OBJ_ORDER,
        K_HALT
    } t_kind;

    typedef struct packed {
        logic [FIELD_BITS-1:0] subject_id;
        logic [FIELD_BITS-1:0] predicate_id;
        logic [FIELD_BITS-1:0] object_id;
        logic [FIELD_BITS-1:0] graph_id;
        logic                  end_of_stream;
    } t_item;

    typedef struct packed {
        logic [2:0]            status;
        logic                  y_bit_valid;
        logic                  y_bit;
        logic                  y_value_valid;
        logic [FIELD_BITS-1:0] y_value;
        logic                  z_bit_valid;
        logic                  z_bit;
        logic                  z_value_valid;
        logic [FIELD_BITS-1:0] z_value;
        logic                  id_bit;
        logic [FIELD_BITS-1:0] graph_value;
    } t_result;

    typedef struct packed {
        t_kind                 kind;
        logic [FIELD_BITS-1:0] pred;
        logic [FIELD_BITS-1:0] obj;
        logic [FIELD_BITS-1:0] graph;
    } t_rec;

    typedef struct packed {
        logic halted;
        logic seen_first;
    } t_front_stat;

    typedef struct packed {
        logic valid;
        logic full;
    } t_q_stat;

endpackage

// ===== src/stbe_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stbe_front
// Classify each triple against the previous one and keep the stream state.
// ----------------------------------------------------------------------------
module stbe_front #(
    parameter int ID_WIDTH = 32
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_push,
    input  stbe_pkg::t_item       i_item,
    output stbe_pkg::t_rec        o_rec,
    output stbe_pkg::t_front_stat o_stat
);

    localparam int CW = (ID_WIDTH < stbe_pkg::FIELD_BITS) ? ID_WIDTH : stbe_pkg::FIELD_BITS;

    logic [CW-1:0]   r_prev_s, r_prev_p, r_prev_o;
    logic            r_seen, r_halted;
    logic [CW-1:0]   n_prev_s, n_prev_p, n_prev_o;
    logic            n_seen, n_halted;
    logic [CW-1:0]   w_s, w_p, w_o, w_g, w_succ;
    stbe_pkg::t_kind w_kind;

    assign w_s    = i_item.subject_id[CW-1:0];
    assign w_p    = i_item.predicate_id[CW-1:0];
    assign w_o    = i_item.object_id[CW-1:0];
    assign w_g    = i_item.graph_id[CW-1:0];
    assign w_succ = r_prev_s + CW'(1);

    always_comb begin
        if (r_halted) begin
            w_kind = stbe_pkg::K_HALT;
        end else if (i_item.end_of_stream) begin
            w_kind = stbe_pkg::K_EOS;
        end else if (w_s == '0 || w_p == '0 || w_o == '0) begin
            w_kind = stbe_pkg::K_ZERO;
        end else if (!r_seen) begin
            w_kind = stbe_pkg::K_FIRST;
        end else if (w_s != r_prev_s) begin
            w_kind = (w_s == w_succ) ? stbe_pkg::K_NEW_SUBJ : stbe_pkg::K_GAP;
        end else if (w_p != r_prev_p) begin
            w_kind = (w_p < r_prev_p) ? stbe_pkg::K_PRED_DEC : stbe_pkg::K_NEW_PRED;
        end else begin
            w_kind = (w_o <= r_prev_o) ? stbe_pkg::K_OBJ_ORDER : stbe_pkg::K_SAME_PRED;
        end
    end

    always_comb begin
        n_prev_s = r_prev_s;
        n_prev_p = r_prev_p;
        n_prev_o = r_prev_o;
        n_seen   = r_seen;
        n_halted = r_halted;
        if (i_push) begin
            case (w_kind)
                stbe_pkg::K_FIRST, stbe_pkg::K_NEW_SUBJ, stbe_pkg::K_NEW_PRED,
                stbe_pkg::K_SAME_PRED: begin
                    n_prev_s = w_s;
                    n_prev_p = w_p;
                    n_prev_o = w_o;
                    n_seen   = 1'b1;
                end
                stbe_pkg::K_EOS: begin
                    n_prev_s = '0;
                    n_prev_p = '0;
                    n_prev_o = '0;
                    n_seen   = 1'b0;
                end
                stbe_pkg::K_GAP, stbe_pkg::K_PRED_DEC, stbe_pkg::K_OBJ_ORDER: begin
                    n_halted = 1'b1;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_s <= '0;
            r_prev_p <= '0;
            r_prev_o <= '0;
            r_seen   <= 1'b0;
            r_halted <= 1'b0;
        end else begin
            r_prev_s <= n_prev_s;
            r_prev_p <= n_prev_p;
            r_prev_o <= n_prev_o;
            r_seen   <= n_seen;
            r_halted <= n_halted;
        end
    end

    assign o_rec.kind  = w_kind;
    assign o_rec.pred  = stbe_pkg::FIELD_BITS'(w_p);
    assign o_rec.obj   = stbe_pkg::FIELD_BITS'(w_o);
    assign o_rec.graph = stbe_pkg::FIELD_BITS'(w_g);

    assign o_stat.halted     = r_halted;
    assign o_stat.seen_first = r_seen;

endmodule

// ===== src/stbe_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stbe_queue
// Two-entry queue of classified records between front and back.
// ----------------------------------------------------------------------------
module stbe_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  stbe_pkg::t_rec    i_rec,
    input  logic              i_pop,
    output stbe_pkg::t_rec    o_rec,
    output stbe_pkg::t_q_stat o_stat
);

    stbe_pkg::t_rec r_mem [2];
    logic           r_wr, r_rd;
    logic [1:0]     r_cnt;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_rec;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr <= ~r_wr;
            end
            if (i_pop) begin
                r_rd <= ~r_rd;
            end
            case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + 2'd1;
                2'b01:   r_cnt <= r_cnt - 2'd1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    assign o_rec        = r_mem[r_rd];
    assign o_stat.valid = (r_cnt != 2'd0);
    assign o_stat.full  = (r_cnt == 2'd2);

endmodule

// ===== src/stbe_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stbe_back
// Expand a classified record into bitmap bits and array values; output register.
// ----------------------------------------------------------------------------
module stbe_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_q_valid,
    input  stbe_pkg::t_rec    i_rec,
    input  logic              i_stall,
    output logic              o_pop,
    output logic              o_valid,
    output stbe_pkg::t_result o_result
);

    logic              r_valid;
    stbe_pkg::t_result r_res;
    stbe_pkg::t_result n_res;
    logic              w_load;
    logic              w_push_triple;

    assign w_load = !r_valid || !i_stall;
    assign o_pop  = i_q_valid && w_load;

    always_comb begin
        n_res         = '0;
        w_push_triple = 1'b0;
        case (i_rec.kind)
            stbe_pkg::K_FIRST: begin
                n_res.y_value_valid = 1'b1;
                n_res.y_value       = i_rec.pred;
                w_push_triple       = 1'b1;
            end
            stbe_pkg::K_NEW_SUBJ: begin
                n_res.y_bit_valid   = 1'b1;
                n_res.y_bit         = 1'b1;
                n_res.y_value_valid = 1'b1;
                n_res.y_value       = i_rec.pred;
                n_res.z_bit_valid   = 1'b1;
                n_res.z_bit         = 1'b1;
                w_push_triple       = 1'b1;
            end
            stbe_pkg::K_NEW_PRED: begin
                n_res.y_bit_valid   = 1'b1;
                n_res.y_value_valid = 1'b1;
                n_res.y_value       = i_rec.pred;
                n_res.z_bit_valid   = 1'b1;
                n_res.z_bit         = 1'b1;
                w_push_triple       = 1'b1;
            end
            stbe_pkg::K_SAME_PRED: begin
                n_res.z_bit_valid = 1'b1;
                w_push_triple     = 1'b1;
            end
            stbe_pkg::K_EOS: begin
                n_res.y_bit_valid = 1'b1;
                n_res.y_bit       = 1'b1;
                n_res.z_bit_valid = 1'b1;
                n_res.z_bit       = 1'b1;
            end
            stbe_pkg::K_ZERO:      n_res.status = stbe_pkg::ST_ZERO_SKIP;
            stbe_pkg::K_GAP:       n_res.status = stbe_pkg::ST_SUBJECT_GAP;
            stbe_pkg::K_PRED_DEC:  n_res.status = stbe_pkg::ST_PRED_DEC;
            stbe_pkg::K_OBJ_ORDER: n_res.status = stbe_pkg::ST_OBJ_ORDER;
            default:               n_res.status = stbe_pkg::ST_HALTED;
        endcase
        if (w_push_triple) begin
            n_res.z_value_valid = 1'b1;
            n_res.z_value       = i_rec.obj;
            if (i_rec.graph != '0) begin
                n_res.id_bit      = 1'b1;
                n_res.graph_value = i_rec.graph;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_load) begin
            r_valid <= i_q_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_res <= n_res;
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_res;

endmodule

// ===== src/sorted_triple_bitmap_encoder.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_triple_bitmap_encoder
// Encode a sorted triple stream into Y/Z/id bitmap bits and array values.
// ----------------------------------------------------------------------------
// Input channel: i_valid / o_stall carry one triple (or end marker) in i_item.
// A transfer happens on a rising edge with i_valid high and o_stall low.
// Output channel: o_valid / i_stall carry one result per input item in
// o_result, in input order.
// Each result passes through the queue and the output register before it is
// offered. Throughput: one item per cycle while o_stall is low.
// The front stage compares each triple with the previous one and updates
// the stream state in the transfer cycle, which is what sets the rate.
// A two-entry queue and the output register hold up to three results while
// the receiver stalls; o_stall rises when the queue is full.
// Reset clears the stream state and the sticky error; after an order error
// every item returns the halted status until reset. ID_WIDTH below 32 takes
// the identifiers modulo 2^ID_WIDTH.
// ----------------------------------------------------------------------------
module sorted_triple_bitmap_encoder #(
    parameter int ID_WIDTH = 32
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  stbe_pkg::t_item   i_item,
    output logic              o_valid,
    input  logic              i_stall,
    output stbe_pkg::t_result o_result
);

    stbe_pkg::t_rec        w_front_rec;
    stbe_pkg::t_rec        w_q_rec;
    stbe_pkg::t_front_stat w_front_stat;
    stbe_pkg::t_q_stat     w_q_stat;
    logic                  w_push;
    logic                  w_pop;

    assign o_stall = w_q_stat.full;
    assign w_push  = i_valid && !w_q_stat.full;

    stbe_front #(
        .ID_WIDTH (ID_WIDTH)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_item  (i_item),
        .o_rec   (w_front_rec),
        .o_stat  (w_front_stat)
    );

    stbe_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_rec   (w_front_rec),
        .i_pop   (w_pop),
        .o_rec   (w_q_rec),
        .o_stat  (w_q_stat)
    );

    stbe_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (w_q_stat.valid),
        .i_rec     (w_q_rec),
        .i_stall   (i_stall),
        .o_pop     (w_pop),
        .o_valid   (o_valid),
        .o_result  (o_result)
    );

    a_halt_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_front_stat.halted |=> w_front_stat.halted)
        else $error("sticky error cleared without reset");

    a_queue_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_q_stat.full && !w_q_stat.valid))
        else $error("queue full but empty");

    a_halt_enters_halted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_push && w_front_stat.halted) |=> w_front_stat.halted && w_q_stat.valid)
        else $error("halted item lost");

    a_emit_only_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_result.z_value_valid || o_result.y_bit_valid))
            |-> o_result.status == stbe_pkg::ST_OK)
        else $error("bits emitted with error status");

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the sorted triple bitmap encoder.
// ----------------------------------------------------------------------------
// Sends directed triples and then random sorted streams with noise items.
// Every accepted item goes through an in-bench encoder model, and each
// returned result is compared field by field with the oldest prediction.
// Both channels idle in random bursts. The run ends with one order error
// (its kind is picked at random) and a few items sent while halted.
// ----------------------------------------------------------------------------
module tb_top;

    logic              i_clk   = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_valid = 1'b0;
    logic              i_stall = 1'b0;
    stbe_pkg::t_item   i_item  = '0;
    logic              o_stall;
    logic              o_valid;
    stbe_pkg::t_result o_result;

    sorted_triple_bitmap_encoder dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_stall  (o_stall),
        .i_item   (i_item),
        .o_valid  (o_valid),
        .i_stall  (i_stall),
        .o_result (o_result)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // encoder model state
    logic [31:0] enc_subject   = '0;
    logic [31:0] enc_predicate = '0;
    logic [31:0] enc_object    = '0;
    logic        enc_seen      = 1'b0;
    logic        enc_halted    = 1'b0;

    // stream generator state
    logic [31:0] gen_s    = '0;
    logic [31:0] gen_p    = '0;
    logic [31:0] gen_o    = '0;
    logic        gen_open = 1'b0;

    stbe_pkg::t_result pending_encodings[$];
    stbe_pkg::t_result oldest_encoding;
    int unsigned       fail_count   = 0;
    int unsigned       stall_left   = 0;
    logic              send_idle_en = 1'b0;
    logic              recv_idle_en = 1'b0;

    function automatic stbe_pkg::t_result encode_triple(input stbe_pkg::t_item it);
        stbe_pkg::t_result r;
        r = '0;
        if (enc_halted) begin
            r.status = stbe_pkg::ST_HALTED;
            return r;
        end
        if (it.end_of_stream) begin
            r.y_bit_valid = 1'b1;
            r.y_bit       = 1'b1;
            r.z_bit_valid = 1'b1;
            r.z_bit       = 1'b1;
            enc_subject   = '0;
            enc_predicate = '0;
            enc_object    = '0;
            enc_seen      = 1'b0;
            return r;
        end
        if (it.subject_id == '0 || it.predicate_id == '0 || it.object_id == '0) begin
            r.status = stbe_pkg::ST_ZERO_SKIP;
            return r;
        end
        if (!enc_seen) begin
            r.y_value_valid = 1'b1;
            r.y_value       = it.predicate_id;
        end else if (it.subject_id != enc_subject) begin
            if (it.subject_id != enc_subject + 32'd1) begin
                r.status   = stbe_pkg::ST_SUBJECT_GAP;
                enc_halted = 1'b1;
                return r;
            end
            r.y_bit_valid   = 1'b1;
            r.y_bit         = 1'b1;
            r.y_value_valid = 1'b1;
            r.y_value       = it.predicate_id;
            r.z_bit_valid   = 1'b1;
            r.z_bit         = 1'b1;
        end else if (it.predicate_id != enc_predicate) begin
            if (it.predicate_id < enc_predicate) begin
                r.status   = stbe_pkg::ST_PRED_DEC;
                enc_halted = 1'b1;
                return r;
            end
            r.y_bit_valid   = 1'b1;
            r.y_bit         = 1'b0;
            r.y_value_valid = 1'b1;
            r.y_value       = it.predicate_id;
            r.z_bit_valid   = 1'b1;
            r.z_bit         = 1'b1;
        end else begin
            if (it.object_id <= enc_object) begin
                r.status   = stbe_pkg::ST_OBJ_ORDER;
                enc_halted = 1'b1;
                return r;
            end
            r.z_bit_valid = 1'b1;
            r.z_bit       = 1'b0;
        end
        r.z_value_valid = 1'b1;
        r.z_value       = it.object_id;
        if (it.graph_id != '0) begin
            r.id_bit      = 1'b1;
            r.graph_value = it.graph_id;
        end
        enc_subject   = it.subject_id;
        enc_predicate = it.predicate_id;
        enc_object    = it.object_id;
        enc_seen      = 1'b1;
        return r;
    endfunction

    function automatic stbe_pkg::t_item make_triple(input logic [31:0] s,
                                                    input logic [31:0] p,
                                                    input logic [31:0] o,
                                                    input logic [31:0] g);
        stbe_pkg::t_item it;
        it.subject_id    = s;
        it.predicate_id  = p;
        it.object_id     = o;
        it.graph_id      = g;
        it.end_of_stream = 1'b0;
        return it;
    endfunction

    function automatic logic [31:0] rand_id();
        logic [31:0] v;
        case ($urandom_range(0, 7))
            0:       v = $urandom_range(1, 16);
            1:       v = 32'hFFFF_FFFF - $urandom_range(0, 4);
            default: v = $urandom;
        endcase
        if (v == '0) begin
            v = 32'd1;
        end
        return v;
    endfunction

    function automatic logic [31:0] rand_step();
        if ($urandom_range(0, 3) == 0) begin
            return $urandom_range(1, 32'h00FF_FFFF);
        end
        return $urandom_range(1, 8);
    endfunction

    function automatic logic [31:0] rand_graph();
        if ($urandom_range(0, 1) == 0) begin
            return '0;
        end
        return $urandom;
    endfunction

    // hold valid across back-to-back transfers; lower it only for an idle burst
    task automatic send_item(input stbe_pkg::t_item it);
        if (send_idle_en && $urandom_range(0, 3) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_item  <= it;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        pending_encodings = {pending_encodings, encode_triple(it)};
    endtask

    task automatic send_end_marker();
        stbe_pkg::t_item it;
        it = {$urandom, $urandom, $urandom, $urandom, 1'b1};
        send_item(it);
        gen_open = 1'b0;
    endtask

    task automatic send_zero_item();
        stbe_pkg::t_item it;
        int unsigned     zero_mask;
        it        = make_triple(rand_id(), rand_id(), rand_id(), rand_graph());
        zero_mask = $urandom_range(1, 7);
        if (zero_mask[0]) it.subject_id   = '0;
        if (zero_mask[1]) it.predicate_id = '0;
        if (zero_mask[2]) it.object_id    = '0;
        send_item(it);
    endtask

    task automatic next_triple();
        stbe_pkg::t_kind kind;
        logic [32:0]     sum;
        int unsigned     pick;
        pick = $urandom_range(0, 9);
        if (!gen_open)     kind = stbe_pkg::K_FIRST;
        else if (pick < 3) kind = stbe_pkg::K_NEW_SUBJ;
        else if (pick < 6) kind = stbe_pkg::K_NEW_PRED;
        else               kind = stbe_pkg::K_SAME_PRED;
        if (kind == stbe_pkg::K_SAME_PRED) begin
            sum = {1'b0, gen_o} + {1'b0, rand_step()};
            if (sum[32]) kind = stbe_pkg::K_NEW_SUBJ;
            else         gen_o = sum[31:0];
        end
        if (kind == stbe_pkg::K_NEW_PRED) begin
            sum = {1'b0, gen_p} + {1'b0, rand_step()};
            if (sum[32]) begin
                kind = stbe_pkg::K_NEW_SUBJ;
            end else begin
                gen_p = sum[31:0];
                gen_o = rand_id();
            end
        end
        if (kind == stbe_pkg::K_NEW_SUBJ) begin
            if (gen_s == '1) begin
                kind = stbe_pkg::K_FIRST;
            end else begin
                gen_s = gen_s + 32'd1;
                gen_p = rand_id();
                gen_o = rand_id();
            end
        end
        if (kind == stbe_pkg::K_FIRST) begin
            if (gen_open) send_end_marker();
            gen_s = rand_id();
            gen_p = rand_id();
            gen_o = rand_id();
        end
        send_item(make_triple(gen_s, gen_p, gen_o, rand_graph()));
        gen_open = 1'b1;
    endtask

    task automatic test_first_triple_and_groups();
        send_end_marker();
        send_item(make_triple(32'd1, 32'd1, 32'd1, 32'd0));
        send_item(make_triple(32'd1, 32'd1, 32'd2, 32'hFFFF_FFFF));
        send_item(make_triple(32'd1, 32'd5, 32'd1, 32'd7));
        send_item(make_triple(32'd2, 32'd1, 32'hFFFF_FFFF, 32'd0));
    endtask

    task automatic test_zero_components();
        send_item(make_triple(32'd0, 32'd1, 32'd3, 32'd1));
        send_item(make_triple(32'd2, 32'd0, 32'd5, 32'd0));
        send_item(make_triple(32'd2, 32'd1, 32'd0, 32'd9));
        send_item(make_triple(32'd0, 32'd0, 32'd0, 32'd0));
        send_item(make_triple(32'd2, 32'hFFFF_FFFF, 32'd1, 32'd1));
    endtask

    task automatic test_end_marker();
        stbe_pkg::t_item it;
        it = '1;
        send_item(it);
        send_end_marker();
        gen_open = 1'b0;
    endtask

    task automatic test_id_extremes();
        send_item(make_triple(32'hFFFF_FFFE, 32'hFFFF_FFFF, 32'hFFFF_FFFE, 32'h8000_0000));
        send_item(make_triple(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd0));
    endtask

    task automatic test_random_streams(input int unsigned n_items);
        int unsigned pick;
        repeat (n_items) begin
            pick = $urandom_range(0, 24);
            if (pick == 0)      send_zero_item();
            else if (pick == 1) send_end_marker();
            else                next_triple();
        end
    endtask

    task automatic test_order_error();
        stbe_pkg::t_kind kind;
        logic [31:0]     s;
        logic [31:0]     p;
        logic [31:0]     o;
        if (!gen_open) next_triple();
        case ($urandom_range(0, 2))
            0:       kind = stbe_pkg::K_GAP;
            1:       kind = stbe_pkg::K_PRED_DEC;
            default: kind = stbe_pkg::K_OBJ_ORDER;
        endcase
        if (kind == stbe_pkg::K_PRED_DEC && gen_p == 32'd1) kind = stbe_pkg::K_GAP;
        case (kind)
            stbe_pkg::K_GAP: begin
                do s = $urandom; while (s == '0 || s == gen_s || s == gen_s + 32'd1);
                p = rand_id();
                o = rand_id();
            end
            stbe_pkg::K_PRED_DEC: begin
                s = gen_s;
                p = $urandom_range(1, gen_p - 32'd1);
                o = rand_id();
            end
            default: begin
                s = gen_s;
                p = gen_p;
                o = ($urandom_range(0, 1) == 0) ? gen_o : $urandom_range(1, gen_o);
            end
        endcase
        send_item(make_triple(s, p, o, rand_graph()));
        // everything after this returns the halted status
        send_end_marker();
        send_zero_item();
        repeat (5) next_triple();
        send_end_marker();
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else if (stall_left != 0) begin
            stall_left <= stall_left - 1;
            i_stall    <= 1'b1;
        end else if (recv_idle_en && $urandom_range(0, 4) == 0) begin
            stall_left <= $urandom_range(0, 5);
            i_stall    <= 1'b1;
        end else begin
            i_stall <= 1'b0;
        end
    end

    task automatic check_field(input string name, input logic [31:0] exp_v,
                               input logic [31:0] act_v);
        if (exp_v !== act_v) begin
            $error("%s: expected %0h, actual %0h", name, exp_v, act_v);
            fail_count++;
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_encodings.size() == 0) begin
                $error("result transfer with no prediction pending, status %0d",
                       o_result.status);
                fail_count++;
            end else begin
                oldest_encoding = pending_encodings.pop_front();
                check_field("status", 32'(oldest_encoding.status),
                            32'(o_result.status));
                check_field("y_bit_valid", 32'(oldest_encoding.y_bit_valid),
                            32'(o_result.y_bit_valid));
                check_field("y_bit", 32'(oldest_encoding.y_bit),
                            32'(o_result.y_bit));
                check_field("y_value_valid", 32'(oldest_encoding.y_value_valid),
                            32'(o_result.y_value_valid));
                check_field("y_value",       oldest_encoding.y_value,       o_result.y_value);
                check_field("z_bit_valid", 32'(oldest_encoding.z_bit_valid),
                            32'(o_result.z_bit_valid));
                check_field("z_bit", 32'(oldest_encoding.z_bit),
                            32'(o_result.z_bit));
                check_field("z_value_valid", 32'(oldest_encoding.z_value_valid),
                            32'(o_result.z_value_valid));
                check_field("z_value",       oldest_encoding.z_value,       o_result.z_value);
                check_field("id_bit", 32'(oldest_encoding.id_bit),
                            32'(o_result.id_bit));
                check_field("graph_value",   oldest_encoding.graph_value,   o_result.graph_value);
            end
        end
    end

    initial begin
        #5_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        send_idle_en = 1'b1;
        recv_idle_en = 1'b1;
        test_first_triple_and_groups();
        test_zero_components();
        test_end_marker();
        test_id_extremes();
        test_end_marker();
        repeat (6) begin
            send_idle_en = ($urandom_range(0, 3) != 0);
            recv_idle_en = ($urandom_range(0, 3) != 0);
            test_random_streams(100);
        end
        send_idle_en = 1'b0;
        recv_idle_en = 1'b0;
        test_random_streams(120);
        test_order_error();
        i_valid <= 1'b0;
        while (pending_encodings.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
